// ===== rtl/msae_pkg.sv =====
// Package for the mail sender address extractor.
// Holds character codes, default sizes, the scan state type and the structs
// passed between the top level, the lexer and the drain unit. No dependencies.
`default_nettype none

package msae_pkg;

    // Default sizes, overridable through the top-level parameters.
    localparam int ADDR_MAX_DEF          = 64;
    localparam int COMMENT_DEPTH_MAX_DEF = 15;

    // Character codes recognized by the lexer.
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_AT     = 8'h40;
    localparam logic [7:0] CH_UP_A   = 8'h41;
    localparam logic [7:0] CH_UP_T   = 8'h54;
    localparam logic [7:0] CH_LO_A   = 8'h61;
    localparam logic [7:0] CH_LO_T   = 8'h74;

    localparam logic [7:0] CRUFT_MAX = 8'hFF;

    // Number of bytes in the lookahead window.
    localparam int WIN_LEN = 4;

    typedef enum logic [1:0] {
        ST_SCAN,
        ST_FLUSH,
        ST_DRAIN
    } msae_state_t;

    // Line state seen by the lexer.
    typedef struct packed {
        logic depth_nz;
        logic in_angle;
        logic in_quote;
        logic done;
        logic at_end;
    } lex_ctx_t;

    // One lexer decision, applied by the top level to its registers.
    typedef struct packed {
        logic [2:0] consume;
        logic       put;
        logic [7:0] put_char;
        logic       bump;
        logic       depth_inc;
        logic       depth_dec;
        logic       set_quote;
        logic       clr_quote;
        logic       open_angle;
        logic       set_done;
    } lex_action_t;

    // Control handed to the drain unit.
    typedef struct packed {
        logic       req;
        logic       trunc;
        logic [7:0] cruft;
    } drain_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/msae_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Holds the gathered address bytes. No dependencies.
`default_nettype none

module msae_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== rtl/msae_lexer.sv =====
// Lexer for the mail sender address extractor: decides the byte at the head
// of the lookahead window. Depends on msae_pkg.
`default_nettype none

module msae_lexer (
    input  logic [3:0][7:0]        win,
    input  logic [2:0]             cnt,
    input  msae_pkg::lex_ctx_t     ctx,
    output msae_pkg::lex_action_t  act
);
    import msae_pkg::*;

    logic       at_match;
    logic       active;
    logic [7:0] head;

    assign head   = win[0];
    assign active = (cnt != 3'd0) && !ctx.done;

    // A space followed by "at" in either case and another space.
    assign at_match = (win[1] inside {CH_LO_A, CH_UP_A}) &&
                      (win[2] inside {CH_LO_T, CH_UP_T}) &&
                      (win[3] == CH_SPACE);

    always_comb
    begin
        act = '0;
        if (active)
        begin
            if (ctx.depth_nz)
            begin
                // Inside a comment only the parentheses matter.
                act.depth_inc = (head == CH_LPAREN);
                act.depth_dec = (head == CH_RPAREN);
                act.consume   = 3'd1;
            end
            else if (ctx.in_angle && (head == CH_GT))
            begin
                // The closing bracket waits for one more byte unless the line ended.
                if ((cnt >= 3'd2) || ctx.at_end)
                begin
                    act.set_done = 1'b1;
                    act.bump     = (cnt < 3'd2) || (win[1] != CH_LF);
                    act.consume  = 3'd1;
                end
            end
            else if (ctx.in_quote)
            begin
                act.clr_quote = (head == CH_QUOTE);
                act.put       = 1'b1;
                act.put_char  = head;
                act.consume   = 3'd1;
            end
            else
            begin
                case (head)
                    CH_SPACE:
                    begin
                        if (cnt == 3'd4)
                        begin
                            if (at_match)
                            begin
                                act.put      = 1'b1;
                                act.put_char = CH_AT;
                                act.consume  = 3'd4;
                            end
                            else
                            begin
                                act.consume = 3'd1;
                            end
                        end
                        else if (ctx.at_end)
                        begin
                            act.consume = 3'd1;
                        end
                    end
                    CH_LT:
                    begin
                        act.open_angle = 1'b1;
                        act.consume    = 3'd1;
                    end
                    CH_LPAREN:
                    begin
                        act.bump      = 1'b1;
                        act.depth_inc = 1'b1;
                        act.consume   = 3'd1;
                    end
                    CH_QUOTE:
                    begin
                        act.set_quote = 1'b1;
                        act.put       = 1'b1;
                        act.put_char  = head;
                        act.consume   = 3'd1;
                    end
                    CH_TAB, CH_LF:
                    begin
                        act.consume = 3'd1;
                    end
                    default:
                    begin
                        act.put      = 1'b1;
                        act.put_char = head;
                        act.consume  = 3'd1;
                    end
                endcase
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/msae_drain.sv =====
// Drain unit for the mail sender address extractor: reads the gathered
// address out of the RAM and presents it on the result stream.
// Depends on msae_pkg; drives the read port of msae_ram.
`default_nettype none

module msae_drain #(
    parameter int  ADDR_MAX = msae_pkg::ADDR_MAX_DEF,
    localparam int AW       = $clog2(ADDR_MAX),
    localparam int LW       = $clog2(ADDR_MAX + 1)
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  msae_pkg::drain_ctl_t   ctl,
    input  logic [LW-1:0]          len,
    output logic                   done,
    output logic                   rd_en,
    output logic [AW-1:0]          rd_addr,
    input  logic [7:0]             rd_data,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [23:0]            m_axis_tdata,  // addr_byte, cruft_count, truncated, zero pad
    output logic                   m_axis_tuser,  // addr_present
    output logic                   m_axis_tlast   // run_last
);
    import msae_pkg::*;

    logic [AW-1:0] idx_reg, idx_next;
    logic          rdv_reg, rdv_next;
    logic          rd_present_reg, rd_last_reg, rd_trunc_reg;
    logic [7:0]    rd_cruft_reg;
    logic          out_valid_reg, out_valid_next;
    logic [7:0]    out_byte_reg, out_cruft_reg;
    logic          out_present_reg, out_last_reg, out_trunc_reg;

    logic out_free, move, rd_free, issue, last_issue, empty;

    assign empty      = (len == '0);
    assign out_free   = !out_valid_reg || m_axis_tready;
    assign move       = rdv_reg && out_free;
    assign rd_free    = !rdv_reg || move;
    assign issue      = ctl.req && rd_free;
    assign last_issue = empty || ((LW'(idx_reg) + LW'(1)) == len);

    assign done    = issue && last_issue;
    assign rd_en   = issue && !empty;
    assign rd_addr = idx_reg;

    always_comb
    begin
        idx_next = idx_reg;
        if (issue)
        begin
            idx_next = last_issue ? '0 : idx_reg + AW'(1);
        end
        rdv_next = issue ? 1'b1 : (move ? 1'b0 : rdv_reg);
        out_valid_next = move ? 1'b1 : (m_axis_tready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            rdv_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            rdv_reg       <= rdv_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Side information travels alongside the RAM read.
    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            rd_present_reg <= !empty;
            rd_last_reg    <= last_issue;
            rd_trunc_reg   <= ctl.trunc;
            rd_cruft_reg   <= ctl.cruft;
        end
        if (move)
        begin
            out_byte_reg    <= rd_present_reg ? rd_data : CH_NUL;
            out_present_reg <= rd_present_reg;
            out_last_reg    <= rd_last_reg;
            out_trunc_reg   <= rd_trunc_reg;
            out_cruft_reg   <= rd_cruft_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'd0, out_trunc_reg, out_cruft_reg, out_byte_reg};
    assign m_axis_tuser  = out_present_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

`default_nettype wire

// ===== rtl/mail_sender_address_extract.sv =====
// Top level of the mail sender address extractor.
// Depends on msae_pkg, msae_ram, msae_lexer and msae_drain.
`default_nettype none

// The block takes the bytes of one mail From line on the input stream, one
// byte per transaction with tlast on the final byte, and returns the sender
// address on the output stream as a run of transactions, one per address
// byte, with tlast on the last one. Comments in parentheses are dropped,
// quoted text is kept as is, tabs, newlines and stray spaces are dropped,
// " at " in any case becomes '@', '<' restarts the address and a '>' after it ends the
// scan. An empty address gives a single transaction with tuser low. The
// cruft count carried on every result is a saturating count kept since
// reset. Within a line one byte is taken per cycle. After the final byte
// the input is held off while the lookahead window of up to four bytes is
// resolved, and while the address is read out of the buffer RAM, one entry
// a cycle through its single read port while the output stream is not
// stalled. The next line is taken as soon as the last read has been
// issued, while earlier results may still wait in the output stages. No
// clearing pass is needed after reset.
module mail_sender_address_extract #(
    parameter int ADDR_MAX          = msae_pkg::ADDR_MAX_DEF,
    parameter int COMMENT_DEPTH_MAX = msae_pkg::COMMENT_DEPTH_MAX_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // line_byte
    input  logic        s_axis_tlast,   // end_of_line
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // addr_byte, cruft_count, truncated, zero pad
    output logic        m_axis_tuser,   // addr_present
    output logic        m_axis_tlast    // run_last
);
    import msae_pkg::*;

    localparam int AW = $clog2(ADDR_MAX);
    localparam int LW = $clog2(ADDR_MAX + 1);
    localparam int DW = $clog2(COMMENT_DEPTH_MAX + 1);

    msae_state_t     state_reg, state_next;
    logic [3:0][7:0] win_reg, win_next, win_shift;
    logic [2:0]      win_cnt_reg, win_cnt_next, cnt_after, cons;
    logic [LW-1:0]   len_reg, len_next;
    logic [DW-1:0]   depth_reg, depth_next;
    logic            angle_reg, angle_next;
    logic            quote_reg, quote_next;
    logic            done_reg, done_next;
    logic            term_reg, term_next;
    logic            ovf_reg, ovf_next;
    logic [7:0]      cruft_reg, cruft_next;

    logic            accept, push, lex_en, bump, drain_done;
    logic            ram_we, rd_en;
    logic [AW-1:0]   rd_addr;
    logic [7:0]      rd_data;
    lex_ctx_t        ctx;
    lex_action_t     act;
    drain_ctl_t      dctl;

    assign s_axis_tready = (state_reg == ST_SCAN);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign lex_en        = (state_reg != ST_DRAIN);

    // A zero byte or the line end means no further bytes will arrive for
    // this line, so the window is resolved without waiting for lookahead.
    assign ctx.depth_nz = (depth_reg != '0);
    assign ctx.in_angle = angle_reg;
    assign ctx.in_quote = quote_reg;
    assign ctx.done     = done_reg || !lex_en;
    assign ctx.at_end   = term_reg;

    msae_lexer u_lexer (
        .win (win_reg),
        .cnt (win_cnt_reg),
        .ctx (ctx),
        .act (act)
    );

    assign cons = act.consume;
    assign bump = act.bump || (act.open_angle && (len_reg != '0));

    // Bytes are only written while the buffer has room.
    assign ram_we = act.put && (len_reg < LW'(ADDR_MAX));

    msae_ram #(
        .WIDTH (8),
        .DEPTH (ADDR_MAX)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (AW'(len_reg)),
        .wdata (act.put_char),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    assign dctl.req   = (state_reg == ST_DRAIN);
    assign dctl.trunc = ovf_reg;
    assign dctl.cruft = cruft_reg;

    msae_drain #(
        .ADDR_MAX (ADDR_MAX)
    ) u_drain (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctl           (dctl),
        .len           (len_reg),
        .done          (drain_done),
        .rd_en         (rd_en),
        .rd_addr       (rd_addr),
        .rd_data       (rd_data),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Line state update: apply the lexer decision, then append the new byte.
    always_comb
    begin
        len_next   = len_reg;
        depth_next = depth_reg;
        angle_next = angle_reg;
        quote_next = quote_reg;
        ovf_next   = ovf_reg;
        cruft_next = cruft_reg;
        done_next  = done_reg || act.set_done;

        if (act.depth_inc && (depth_reg < DW'(COMMENT_DEPTH_MAX)))
        begin
            depth_next = depth_reg + DW'(1);
        end
        if (act.depth_dec)
        begin
            depth_next = depth_reg - DW'(1);
        end
        if (act.set_quote)
        begin
            quote_next = 1'b1;
        end
        if (act.clr_quote)
        begin
            quote_next = 1'b0;
        end
        if (act.open_angle)
        begin
            angle_next = 1'b1;
            len_next   = '0;
            ovf_next   = 1'b0;
        end
        if (act.put)
        begin
            if (ram_we)
            begin
                len_next = len_reg + LW'(1);
            end
            else
            begin
                ovf_next = 1'b1;
            end
        end
        if (bump && (cruft_reg != CRUFT_MAX))
        begin
            cruft_next = cruft_reg + 8'd1;
        end

        // Drop the consumed bytes from the front of the window.
        case (cons)
            3'd1:    win_shift = {8'h00, win_reg[3:1]};
            3'd4:    win_shift = '0;
            default: win_shift = win_reg;
        endcase
        cnt_after = win_cnt_reg - cons;

        push = accept && !term_reg && !done_next && (s_axis_tdata != CH_NUL);
        win_next = win_shift;
        if (push)
        begin
            win_next[cnt_after[1:0]] = s_axis_tdata;
        end
        win_cnt_next = done_next ? 3'd0 : (cnt_after + {2'b00, push});

        term_next = term_reg || (accept && (s_axis_tlast || (s_axis_tdata == CH_NUL)));

        state_next = state_reg;
        case (state_reg)
            ST_SCAN:
            begin
                if (accept && s_axis_tlast)
                begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                if ((win_cnt_reg == 3'd0) || done_reg)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (drain_done)
                begin
                    state_next = ST_SCAN;
                end
            end
            default:
            begin
                state_next = ST_SCAN;
            end
        endcase

        // The last read of the run has been issued: the line starts over.
        if (drain_done)
        begin
            len_next     = '0;
            depth_next   = '0;
            angle_next   = 1'b0;
            quote_next   = 1'b0;
            done_next    = 1'b0;
            term_next    = 1'b0;
            ovf_next     = 1'b0;
            win_cnt_next = 3'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_SCAN;
            win_cnt_reg <= 3'd0;
            len_reg     <= '0;
            depth_reg   <= '0;
            angle_reg   <= 1'b0;
            quote_reg   <= 1'b0;
            done_reg    <= 1'b0;
            term_reg    <= 1'b0;
            ovf_reg     <= 1'b0;
            cruft_reg   <= 8'd0;
        end
        else
        begin
            state_reg   <= state_next;
            win_cnt_reg <= win_cnt_next;
            len_reg     <= len_next;
            depth_reg   <= depth_next;
            angle_reg   <= angle_next;
            quote_reg   <= quote_next;
            done_reg    <= done_next;
            term_reg    <= term_next;
            ovf_reg     <= ovf_next;
            cruft_reg   <= cruft_next;
        end
    end

    // Window bytes are qualified by the window count.
    always_ff @(posedge clk)
    begin
        win_reg <= win_next;
    end

`ifndef SYNTH
    // The window never holds more bytes than it has room for.
    assert property (@(posedge clk) disable iff (!rst_n) win_cnt_reg <= 3'd4)
        else $error("lookahead window overfilled");

    // The buffer is only read out once the window has been resolved.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DRAIN) |-> ((win_cnt_reg == 3'd0) || done_reg))
        else $error("drain started with unresolved lookahead");

    // An empty address is reported as a single result with a zero byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tlast && (m_axis_tdata[7:0] == CH_NUL)))
        else $error("empty address result malformed");

    // The final byte of a line holds off further input until the run is read.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && s_axis_tlast) |=> !s_axis_tready)
        else $error("input taken directly after line end");
`endif

endmodule

`default_nettype wire
